// ===== hw/rtl/gb3_pkg.sv =====
// Shared types, constants and register codes for the 3x3 Gaussian blur block.
// Used by every module in hw/rtl except gb3_ram; depends on nothing else.
package gb3_pkg;

    // Default parameter values handed to the top level.
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int WEIGHT_BITS_DEF = 16;

    // Fixed field widths.
    localparam int PIX_W     = 8;
    localparam int ROW_W     = 12;
    localparam int CFG_WID_W = 11;
    localparam int WGT_W     = 16;
    // Width used to clamp the line width against any allowed MAX_WIDTH.
    localparam int WCMP_W    = 13;

    // Configuration port geometry.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes (byte address is 4 times the index).
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_CORNER_WEIGHT = 3'd2;
    localparam logic [2:0] REG_EDGE_WEIGHT   = 3'd3;
    localparam logic [2:0] REG_CENTER_WEIGHT = 3'd4;

    // Register reset values.
    localparam logic [CFG_WID_W-1:0] RST_IMAGE_WIDTH   = 11'd640;
    localparam logic [ROW_W-1:0]     RST_IMAGE_HEIGHT  = 12'd480;
    localparam logic [WGT_W-1:0]     RST_CORNER_WEIGHT = 16'd741;
    localparam logic [WGT_W-1:0]     RST_EDGE_WEIGHT   = 16'd5492;
    localparam logic [WGT_W-1:0]     RST_CENTER_WEIGHT = 16'd40587;

    // Input item.
    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             flush;
    } gb3_in_t;

    // Result item.
    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             end_of_frame;
    } gb3_out_t;

    // Configuration register set.
    typedef struct packed {
        logic [CFG_WID_W-1:0] image_width;
        logic [ROW_W-1:0]     image_height;
        logic [WGT_W-1:0]     corner_weight;
        logic [WGT_W-1:0]     edge_weight;
        logic [WGT_W-1:0]     center_weight;
    } gb3_cfg_t;

    // Control that travels with a window into the weighting stage.
    typedef struct packed {
        logic             interior;
        logic             eof;
        logic [PIX_W-1:0] pass_value;
    } gb3_tag_t;

    // 3x3 neighbourhood, indexed row*3+col.
    typedef logic [8:0][PIX_W-1:0] gb3_win_t;

endpackage

// ===== hw/rtl/gaussian_blur_3x3_top.sv =====
// Top level of the 3x3 Gaussian blur block: registers, line buffer and weighting.
// Depends on gb3_pkg, gb3_regs, gb3_linebuf, gb3_mac and gb3_ram.
//
// Usage:
//   Input items (in_data) carry one raster pixel or a flush mark; an item is
//   taken at a clock edge where in_valid is high and in_stall is low. Result
//   items (out_data) leave the same way on out_valid / out_stall, in raster
//   order, W+1 positions behind the input. After the frame's last pixel,
//   W+1 flush items drain the pending border outputs; end_of_frame marks
//   the frame's final output. Flush items inside the frame give no result.
//   Throughput is one item per cycle unless stalled: each line store takes
//   one read and one write per cycle. Items pass the read, window, product
//   and output stages. After reset both line stores are zeroed, one column
//   per cycle; in_stall stays high meanwhile, while the register port works
//   as usual. A stalled receiver holds the output register; the three
//   stages in front of it keep filling, so in_stall rises only once every
//   stage holds an item. The user must write registers over the APB port
//   only while no item is in flight; the block does not enforce this.
module gaussian_blur_3x3_top #(
    parameter int MAX_WIDTH   = gb3_pkg::MAX_WIDTH_DEF,
    parameter int WEIGHT_BITS = gb3_pkg::WEIGHT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gb3_pkg::ADDR_W-1:0] paddr,
    input  logic [gb3_pkg::DATA_W-1:0] pwdata,
    output logic [gb3_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    input  gb3_pkg::gb3_in_t           in_data,
    output logic                       in_stall,
    output logic                       out_valid,
    output gb3_pkg::gb3_out_t          out_data,
    input  logic                       out_stall
);

    gb3_pkg::gb3_cfg_t cfg;
    logic              s2_valid;
    gb3_pkg::gb3_tag_t s2_tag;
    gb3_pkg::gb3_win_t s2_win;
    logic              mac_ready;

    // Configuration registers.
    gb3_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Counters, line stores and window.
    gb3_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .in_stall  (in_stall),
        .s2_valid  (s2_valid),
        .s2_tag    (s2_tag),
        .s2_win    (s2_win),
        .mac_ready (mac_ready)
    );

    // Weighting and output register.
    gb3_mac #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s2_valid  (s2_valid),
        .s2_tag    (s2_tag),
        .s2_win    (s2_win),
        .mac_ready (mac_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall)
    );

endmodule

// ===== hw/rtl/gb3_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the line stores; depends on nothing else.
module gb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/gb3_regs.sv =====
// APB-style configuration registers of the blur block.
// Depends on gb3_pkg for the register codes, reset values and the register struct.
module gb3_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gb3_pkg::ADDR_W-1:0]  paddr,
    input  logic [gb3_pkg::DATA_W-1:0]  pwdata,
    output logic [gb3_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output gb3_pkg::gb3_cfg_t           cfg
);

    gb3_pkg::gb3_cfg_t cfg_reg;
    logic [2:0]        reg_index;
    logic              wr_strobe;

    assign reg_index = paddr[4:2];
    assign wr_strobe = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Register writes in the access cycle; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width   <= gb3_pkg::RST_IMAGE_WIDTH;
            cfg_reg.image_height  <= gb3_pkg::RST_IMAGE_HEIGHT;
            cfg_reg.corner_weight <= gb3_pkg::RST_CORNER_WEIGHT;
            cfg_reg.edge_weight   <= gb3_pkg::RST_EDGE_WEIGHT;
            cfg_reg.center_weight <= gb3_pkg::RST_CENTER_WEIGHT;
        end
        else if (wr_strobe)
        begin
            case (reg_index)
                gb3_pkg::REG_IMAGE_WIDTH:
                    cfg_reg.image_width <= pwdata[gb3_pkg::CFG_WID_W-1:0];
                gb3_pkg::REG_IMAGE_HEIGHT:
                    cfg_reg.image_height <= pwdata[gb3_pkg::ROW_W-1:0];
                gb3_pkg::REG_CORNER_WEIGHT:
                    cfg_reg.corner_weight <= pwdata[gb3_pkg::WGT_W-1:0];
                gb3_pkg::REG_EDGE_WEIGHT:
                    cfg_reg.edge_weight <= pwdata[gb3_pkg::WGT_W-1:0];
                gb3_pkg::REG_CENTER_WEIGHT:
                    cfg_reg.center_weight <= pwdata[gb3_pkg::WGT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        case (reg_index)
            gb3_pkg::REG_IMAGE_WIDTH:
                prdata = gb3_pkg::DATA_W'(cfg_reg.image_width);
            gb3_pkg::REG_IMAGE_HEIGHT:
                prdata = gb3_pkg::DATA_W'(cfg_reg.image_height);
            gb3_pkg::REG_CORNER_WEIGHT:
                prdata = gb3_pkg::DATA_W'(cfg_reg.corner_weight);
            gb3_pkg::REG_EDGE_WEIGHT:
                prdata = gb3_pkg::DATA_W'(cfg_reg.edge_weight);
            gb3_pkg::REG_CENTER_WEIGHT:
                prdata = gb3_pkg::DATA_W'(cfg_reg.center_weight);
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/gb3_linebuf.sv =====
// Raster counters, the two line stores, the read stage and the 3x3 window.
// Depends on gb3_pkg and gb3_ram; feeds windows and their control to gb3_mac.
module gb3_linebuf #(
    parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gb3_pkg::gb3_cfg_t cfg,
    input  logic              in_valid,
    input  gb3_pkg::gb3_in_t  in_data,
    output logic              in_stall,
    output logic              s2_valid,
    output gb3_pkg::gb3_tag_t s2_tag,
    output gb3_pkg::gb3_win_t s2_win,
    input  logic              mac_ready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int RW = gb3_pkg::ROW_W;
    localparam int PW = gb3_pkg::PIX_W;
    localparam int HW = gb3_pkg::WCMP_W;

    // Effective frame size.
    logic [HW-1:0] w_raw;
    logic [HW-1:0] w_clamp;
    logic [WW-1:0] w;
    logic [RW-1:0] h;

    assign w_raw   = HW'(cfg.image_width);
    assign w_clamp = (w_raw < HW'(3)) ? HW'(3) :
                     ((w_raw > HW'(MAX_WIDTH)) ? HW'(MAX_WIDTH) : w_raw);
    assign w       = w_clamp[WW-1:0];
    assign h       = (cfg.image_height < RW'(3)) ? RW'(3) : cfg.image_height;

    // Position counters and the clearing pass.
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic          clearing_reg;
    logic [CW-1:0] clr_addr_reg;

    // Read stage registers.
    logic          s1_v_reg;
    logic          s1_pix_reg;
    logic          s1_emit_reg;
    logic          s1_drain_reg;
    logic          s1_sel_mid_reg;
    logic          s1_interior_reg;
    logic          s1_eof_reg;
    logic [PW-1:0] s1_pixel_reg;
    logic [CW-1:0] s1_addr_reg;
    logic          hit_reg;
    logic [PW-1:0] byp_up_reg;
    logic [PW-1:0] byp_mid_reg;

    // Window stage registers.
    logic              s2_v_reg;
    gb3_pkg::gb3_tag_t s2_tag_reg;
    gb3_pkg::gb3_win_t win_reg;

    logic          s2_ready;
    logic          s1_ready;
    logic          accept;
    logic          drain;
    logic          pix_item;
    logic          fire;
    logic          emit;
    logic          col_last_in;
    logic          out_last_row;
    logic          out_last_col;
    logic          eof;
    logic          interior;
    logic [CW-1:0] rd_addr;
    logic          wr_s1;
    logic [PW-1:0] up_rdata;
    logic [PW-1:0] mid_rdata;
    logic [PW-1:0] up_data;
    logic [PW-1:0] mid_data;
    logic          ram_we;
    logic [CW-1:0] ram_waddr;
    logic [PW-1:0] up_wdata;
    logic [PW-1:0] mid_wdata;

    // Handshake through the stage chain.
    assign s2_ready = !s2_v_reg || mac_ready;
    assign s1_ready = !s1_v_reg || s2_ready;
    assign in_stall = clearing_reg || !s1_ready;
    assign accept   = in_valid && !in_stall;

    // Item classification from the current positions.
    assign drain        = in_row_reg >= h;
    assign pix_item     = !drain && !in_data.flush;
    assign fire         = (in_row_reg >= RW'(2)) ||
                          ((in_row_reg == RW'(1)) && (in_col_reg != '0));
    assign emit         = drain || (pix_item && fire);
    assign col_last_in  = (WW'(in_col_reg) + WW'(1)) >= w;
    assign out_last_row = ((RW + 1)'(out_row_reg) + (RW + 1)'(1)) >= (RW + 1)'(h);
    assign out_last_col = (WW'(out_col_reg) + WW'(1)) >= w;
    assign eof          = (out_row_reg >= h) || (out_last_row && out_last_col);
    assign interior     = (out_row_reg != '0) && !out_last_row &&
                          (out_col_reg != '0) && !out_last_col;
    assign rd_addr      = drain ? out_col_reg : in_col_reg;

    // Next positions; the frame's final output rewinds all counters.
    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (accept)
        begin
            if (pix_item)
            begin
                if (col_last_in)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + RW'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + CW'(1);
                end
            end
            if (emit)
            begin
                if (eof)
                begin
                    in_row_next  = '0;
                    in_col_next  = '0;
                    out_row_next = '0;
                    out_col_next = '0;
                end
                else if (out_last_col)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + RW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end
        else
        begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

    // Zero both line stores one column per cycle after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + CW'(1);
            if (clr_addr_reg == CW'(MAX_WIDTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // The read stage writes a pixel item back when it moves on. A read issued in
    // that same cycle at the same column takes the written values from the bypass.
    assign wr_s1    = s1_v_reg && s1_pix_reg && s2_ready;
    assign up_data  = hit_reg ? byp_up_reg : up_rdata;
    assign mid_data = hit_reg ? byp_mid_reg : mid_rdata;

    assign ram_we    = clearing_reg || wr_s1;
    assign ram_waddr = clearing_reg ? clr_addr_reg : s1_addr_reg;
    assign up_wdata  = clearing_reg ? '0 : mid_data;
    assign mid_wdata = clearing_reg ? '0 : s1_pixel_reg;

    gb3_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (up_wdata),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (up_rdata)
    );

    gb3_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (mid_wdata),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (mid_rdata)
    );

    // Read stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_v_reg <= accept && (pix_item || drain);
            hit_reg  <= accept && wr_s1 && (rd_addr == s1_addr_reg);
        end
    end

    // Read stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg      <= pix_item;
            s1_emit_reg     <= emit;
            s1_drain_reg    <= drain;
            s1_sel_mid_reg  <= out_last_row;
            s1_interior_reg <= interior && !drain;
            s1_eof_reg      <= eof;
            s1_pixel_reg    <= in_data.pixel_in;
            s1_addr_reg     <= rd_addr;
            byp_up_reg      <= mid_data;
            byp_mid_reg     <= s1_pixel_reg;
        end
    end

    // Window shift and hand-off to the weighting stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
            win_reg  <= '0;
        end
        else if (s2_ready)
        begin
            s2_v_reg <= s1_v_reg && s1_emit_reg;
            if (s1_v_reg && s1_pix_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r * 3]     <= win_reg[r * 3 + 1];
                    win_reg[r * 3 + 1] <= win_reg[r * 3 + 2];
                end
                win_reg[2] <= up_data;
                win_reg[5] <= mid_data;
                win_reg[8] <= s1_pixel_reg;
            end
        end
    end

    // Border and drain values are settled here; the center after the shift
    // is the present right-middle pixel.
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_v_reg)
        begin
            s2_tag_reg.interior <= s1_interior_reg;
            s2_tag_reg.eof      <= s1_eof_reg;
            if (s1_drain_reg)
            begin
                s2_tag_reg.pass_value <= s1_sel_mid_reg ? mid_data : up_data;
            end
            else
            begin
                s2_tag_reg.pass_value <= win_reg[5];
            end
        end
    end

    assign s2_valid = s2_v_reg;
    assign s2_tag   = s2_tag_reg;
    assign s2_win   = win_reg;

    // The clearing pass runs once, right after reset.
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clearing_reg |=> !clearing_reg)
        else $error("line store clearing restarted");

    // No item is in flight while the stores are being cleared.
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!s1_v_reg && !s2_v_reg))
        else $error("item in flight during clearing");

    // A bypass hit always belongs to an item in the read stage.
    a_hit_owner: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> s1_v_reg)
        else $error("bypass hit without read stage item");

    // A window waiting for the weighting stage is not disturbed.
    a_win_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_v_reg && !mac_ready) |=> $stable(win_reg))
        else $error("window changed while its item was stalled");

endmodule

// ===== hw/rtl/gb3_mac.sv =====
// Weighting of the 3x3 window, rounding, saturation and the output register.
// Depends on gb3_pkg; takes windows from gb3_linebuf.
module gb3_mac #(
    parameter int WEIGHT_BITS = gb3_pkg::WEIGHT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gb3_pkg::gb3_cfg_t cfg,
    input  logic              s2_valid,
    input  gb3_pkg::gb3_tag_t s2_tag,
    input  gb3_pkg::gb3_win_t s2_win,
    output logic              mac_ready,
    output logic              out_valid,
    output gb3_pkg::gb3_out_t out_data,
    input  logic              out_stall
);

    localparam int PW     = gb3_pkg::PIX_W;
    localparam int GW     = gb3_pkg::WGT_W;
    localparam int GRP_W  = PW + 2;
    localparam int PRD_W  = GRP_W + GW;
    localparam int CTR_W  = PW + GW;
    localparam int SUM_W  = PRD_W + 3;

    logic [GRP_W-1:0] corners;
    logic [GRP_W-1:0] edges;

    logic              s3_v_reg;
    gb3_pkg::gb3_tag_t s3_tag_reg;
    logic [PRD_W-1:0]  p_corner_reg;
    logic [PRD_W-1:0]  p_edge_reg;
    logic [CTR_W-1:0]  p_center_reg;

    logic              out_v_reg;
    gb3_pkg::gb3_out_t out_reg;

    logic             out_ready;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] shifted;
    logic [PW-1:0]    blurred;

    assign out_ready = !out_v_reg || !out_stall;
    assign mac_ready = !s3_v_reg || out_ready;

    // Group sums of the diagonal and orthogonal neighbours.
    assign corners = GRP_W'(s2_win[0]) + GRP_W'(s2_win[2]) +
                     GRP_W'(s2_win[6]) + GRP_W'(s2_win[8]);
    assign edges   = GRP_W'(s2_win[1]) + GRP_W'(s2_win[3]) +
                     GRP_W'(s2_win[5]) + GRP_W'(s2_win[7]);

    // Product stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (mac_ready)
        begin
            s3_v_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mac_ready && s2_valid)
        begin
            s3_tag_reg   <= s2_tag;
            p_corner_reg <= corners * cfg.corner_weight;
            p_edge_reg   <= edges * cfg.edge_weight;
            p_center_reg <= s2_win[4] * cfg.center_weight;
        end
    end

    // Sum, round half up and saturate at full scale.
    assign sum     = SUM_W'(p_corner_reg) + SUM_W'(p_edge_reg) +
                     SUM_W'(p_center_reg) + (SUM_W'(1) << (WEIGHT_BITS - 1));
    assign shifted = sum >> WEIGHT_BITS;
    assign blurred = (shifted > SUM_W'(255)) ? {PW{1'b1}} : shifted[PW-1:0];

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s3_v_reg)
        begin
            out_reg.pixel_out    <= s3_tag_reg.interior ? blurred : s3_tag_reg.pass_value;
            out_reg.end_of_frame <= s3_tag_reg.eof;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

endmodule
